// File: rtl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

    // tick counter width; fixed at the width of the tick_now field
    localparam int TICK_BITS  = 32;
    localparam int CFG_BITS   = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int KIND_BITS  = 2;
    localparam int TALLY_BITS = 4;

    // stream widths, padded to whole bytes
    localparam int S_DATA_BITS = ((TICK_BITS + 1 + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((KIND_BITS + TICK_BITS + 7) / 8) * 8;

    localparam logic signed [TALLY_BITS-1:0] TALLY_MAX  = 4'sd7;
    localparam logic signed [TALLY_BITS-1:0] TALLY_LONG = -4'sd1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_HOLD_OFF   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_COMMIT     = 2'd2,
        REG_DISCARD    = 2'd3
    } cfg_addr_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_NONE   = 2'd0,
        KIND_SINGLE = 2'd1,
        KIND_DOUBLE = 2'd2,
        KIND_LONG   = 2'd3
    } click_kind_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] hold_off_ticks;
        logic [CFG_BITS-1:0] long_press_ticks;
        logic [CFG_BITS-1:0] commit_ticks;
        logic [CFG_BITS-1:0] discard_ticks;
    } cfg_t;

    typedef struct packed {
        logic                 button_down;
        logic [TICK_BITS-1:0] tick_now;
    } sample_t;

    typedef struct packed {
        logic [TICK_BITS-1:0] ticks_since_action;
        click_kind_t          click_kind;
    } result_t;

    typedef struct packed {
        logic                         pressed;
        logic signed [TALLY_BITS-1:0] tally;
    } core_status_t;

endpackage

`default_nettype wire

// File: rtl/button_click_classifier_top.sv
// ----------------------------------------------------------------------------
// button_click_classifier_top
// Debounced button sampler that reports single, double and long presses.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one sample per request, tdata = {button_down, tick_now}.
//   m_ channel: one result per sample, tdata = {ticks_since_action, click_kind}.
//   cfg_ port: write hold-off, long-press, commit and discard thresholds
//   (indexes 0..3) while no sample is in flight; values apply at once.
//   Path: an accepted sample is captured in the input register; its result
//   is then captured in the result register once the output side is not
//   stalled. Throughput: one sample per cycle unless the output stalls,
//   set by the single debounce/classify pass between the two registers.
//   Reset (aresetn low, synchronous) empties both registers, clears the
//   button state and click tally and restores the default thresholds.
//   When m_tready is low the result holds; the input register still takes
//   one more sample, after which s_tready drops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_classifier_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // tdata: tick_now[31:0], button_down[32], zero pad
    input  wire logic [bcc_pkg::S_DATA_BITS-1:0] s_tdata,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // tdata: click_kind[1:0], ticks_since_action[33:2], zero pad
    output      logic [bcc_pkg::M_DATA_BITS-1:0] m_tdata,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bcc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [bcc_pkg::CFG_BITS-1:0]    cfg_wr_data
);

    bcc_pkg::cfg_t         cfg;
    bcc_pkg::result_t      result;
    bcc_pkg::core_status_t status;

    bcc_pkg::sample_t sample_reg, sample_next;
    logic             in_valid_reg, in_valid_next;
    bcc_pkg::result_t out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             advance;
    logic             s_take;

    bcc_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    bcc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .sample  (sample_reg),
        .advance (advance),
        .result  (result),
        .status  (status)
    );

    always_comb begin
        out_free = !out_valid_reg || m_tready;
        advance  = in_valid_reg && out_free;
        s_tready = !in_valid_reg || advance;
        s_take   = s_tvalid && s_tready;

        sample_next   = sample_reg;
        in_valid_next = in_valid_reg;
        if (s_take) begin
            sample_next.tick_now    = s_tdata[bcc_pkg::TICK_BITS-1:0];
            sample_next.button_down = s_tdata[bcc_pkg::TICK_BITS];
            in_valid_next           = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_next       = result;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bcc_pkg::M_DATA_BITS - bcc_pkg::KIND_BITS - bcc_pkg::TICK_BITS){1'b0}},
                       out_reg.ticks_since_action, out_reg.click_kind};

    // a moved sample always shows up as a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("result lost after core advance");

    // never overwrite a held sample while the output is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted over a stalled sample");

    // tally never falls below the long-press marker
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.tally >= bcc_pkg::TALLY_LONG)
        else $error("click tally out of range");

    // a long-press marker only survives while the button stays down
    assert property (@(posedge aclk) disable iff (!aresetn)
        (status.tally == bcc_pkg::TALLY_LONG) |-> status.pressed)
        else $error("long-press marker with button released");

endmodule

`default_nettype wire

// File: rtl/bcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bcc_cfg_regs
// Timing threshold registers, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [bcc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [bcc_pkg::CFG_BITS-1:0]   cfg_wr_data,
    output bcc_pkg::cfg_t                       cfg
);

    bcc_pkg::cfg_t cfg_reg;
    bcc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (bcc_pkg::cfg_addr_t'(cfg_addr))
                bcc_pkg::REG_HOLD_OFF:   cfg_next.hold_off_ticks   = cfg_wr_data;
                bcc_pkg::REG_LONG_PRESS: cfg_next.long_press_ticks = cfg_wr_data;
                bcc_pkg::REG_COMMIT:     cfg_next.commit_ticks     = cfg_wr_data;
                bcc_pkg::REG_DISCARD:    cfg_next.discard_ticks    = cfg_wr_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_off_ticks   <= 32'd50;
            cfg_reg.long_press_ticks <= 32'd1000;
            cfg_reg.commit_ticks     <= 32'd300;
            cfg_reg.discard_ticks    <= 32'd1000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/bcc_core.sv
// ----------------------------------------------------------------------------
// bcc_core
// Debounce and classify state; computes one result per sample.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bcc_pkg::cfg_t     cfg,
    input  wire bcc_pkg::sample_t  sample,
    input  wire logic              advance,
    output bcc_pkg::result_t       result,
    output bcc_pkg::core_status_t  status
);

    logic                                  pressed_reg, pressed_next;
    logic [bcc_pkg::TICK_BITS-1:0]         press_tick_reg, press_tick_next;
    logic [bcc_pkg::TICK_BITS-1:0]         release_tick_reg, release_tick_next;
    logic signed [bcc_pkg::TALLY_BITS-1:0] tally_reg, tally_next;

    logic                                  gate_open;
    logic                                  press_acc;
    logic                                  release_acc;
    logic [bcc_pkg::TICK_BITS-1:0]         diff_release;
    logic [bcc_pkg::TICK_BITS-1:0]         diff_press;
    logic [bcc_pkg::TICK_BITS-1:0]         since_release;
    logic [bcc_pkg::TICK_BITS-1:0]         since_press;
    logic [bcc_pkg::TICK_BITS-1:0]         later_tick;
    logic signed [bcc_pkg::TALLY_BITS-1:0] tally_deb;
    bcc_pkg::click_kind_t                  kind;

    always_comb begin
        diff_release = sample.tick_now - release_tick_reg;
        diff_press   = sample.tick_now - press_tick_reg;
        gate_open    = diff_release > cfg.hold_off_ticks;
        press_acc    = gate_open && sample.button_down && !pressed_reg;
        release_acc  = gate_open && !sample.button_down && pressed_reg;

        // debounce
        pressed_next      = pressed_reg;
        press_tick_next   = press_tick_reg;
        release_tick_next = release_tick_reg;
        tally_deb         = tally_reg;
        if (press_acc) begin
            pressed_next    = 1'b1;
            press_tick_next = sample.tick_now;
        end else if (release_acc) begin
            pressed_next      = 1'b0;
            release_tick_next = sample.tick_now;
            if (tally_reg < bcc_pkg::TALLY_MAX) begin
                tally_deb = tally_reg + 4'sd1;
            end
        end

        since_release = release_acc ? '0 : diff_release;
        since_press   = press_acc ? '0 : diff_press;

        // classify
        kind       = bcc_pkg::KIND_NONE;
        tally_next = tally_deb;
        if (tally_deb == 4'sd0 && pressed_next && since_press > cfg.long_press_ticks) begin
            tally_next = bcc_pkg::TALLY_LONG;
            kind       = bcc_pkg::KIND_LONG;
        end else if (since_release > cfg.commit_ticks && !pressed_next) begin
            if (tally_deb == 4'sd1) begin
                tally_next = 4'sd0;
                kind       = bcc_pkg::KIND_SINGLE;
            end else if (tally_deb == 4'sd2) begin
                tally_next = 4'sd0;
                kind       = bcc_pkg::KIND_DOUBLE;
            end else if (since_release > cfg.discard_ticks) begin
                tally_next = 4'sd0;
            end
        end

        // raw compare picks the later action, no wrap correction
        later_tick = (press_tick_next > release_tick_next) ? press_tick_next
                                                           : release_tick_next;
        result.click_kind         = kind;
        result.ticks_since_action = sample.tick_now - later_tick;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg      <= 1'b0;
            press_tick_reg   <= '0;
            release_tick_reg <= '0;
            tally_reg        <= '0;
        end else if (advance) begin
            pressed_reg      <= pressed_next;
            press_tick_reg   <= press_tick_next;
            release_tick_reg <= release_tick_next;
            tally_reg        <= tally_next;
        end
    end

    assign status.pressed = pressed_reg;
    assign status.tally   = tally_reg;

endmodule

`default_nettype wire
